/* rtl/core/abde_pkg.sv */
// Shared constants, request codes and types of the adjacency bit-matrix degree engine.
`default_nettype none

package abde_pkg;

    // Geometry of one adjacency word and of the vertex mask.
    localparam int WORD_BITS        = 64;
    localparam int MASK_WORDS       = 4;
    localparam int MAX_VERTICES_DEF = 256;

    // Field widths.
    localparam int REQ_W   = 3;
    localparam int VTX_W   = 8;
    localparam int MIDX_W  = 2;
    localparam int DEG_W   = 9;
    localparam int EDGE_W  = 15;
    localparam int BLK_W   = 3;
    localparam int CNT_W   = 7;

    // Request codes carried in s_tuser.
    localparam logic [REQ_W-1:0] REQ_ADD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MASK     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEG_CAP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEG_MUP  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEG_UP   = 3'd5;

    // Control of the shared popcount accumulator.
    typedef struct packed {
        logic clr;
        logic add;
    } acc_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/abde_mem.sv */
// Adjacency word store: one write port and one registered read port.
`default_nettype none

module abde_mem
    import abde_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        waddr,
    input  wire logic [WORD_BITS-1:0] wdata,
    input  wire logic [AW-1:0]        raddr,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/abde_popacc.sv */
// Shared popcount and accumulate unit: adds the set bits of one kept word per beat.
`default_nettype none

module abde_popacc
    import abde_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire acc_ctl_t             ctl,
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [WORD_BITS-1:0] keep,
    output logic      [DEG_W-1:0]     sum
);

    // Byte-wise bit count, then a sum of the eight byte counts.
    function automatic logic [CNT_W-1:0] popcnt64(input logic [WORD_BITS-1:0] x);
        logic [3:0]       b [8];
        logic [CNT_W-1:0] s;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            b[k] = '0;
            for (int j = 0; j < 8; j++) begin
                b[k] = b[k] + 4'(x[8*k+j]);
            end
        end
        for (int k = 0; k < 8; k++) begin
            s = s + CNT_W'(b[k]);
        end
        return s;
    endfunction

    logic [DEG_W-1:0] sum_reg;
    logic [DEG_W-1:0] sum_next;

    // Accumulator update.
    always_comb begin
        sum_next = sum_reg;
        if (ctl.clr) begin
            sum_next = '0;
        end else if (ctl.add) begin
            sum_next = sum_reg + DEG_W'(popcnt64(word & keep));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

`default_nettype wire

/* rtl/core/adjacency_bitmatrix_degree_engine.sv */
// Top level of the adjacency bit-matrix degree engine: sequencer, mask and edge count.
//
//  channel   | dir | contents
//  ----------+-----+---------------------------------------------------------
//  s_        | in  | tuser req_type; tdata vertex, other_vertex, mask_index,
//            |     | mask_word, upper_bound
//  m_        | out | tuser bad_vertex; tdata degree_count, edge_count
//  cfg_      | in  | data blocks_in_use (always ready)
//
// After reset a clearing pass writes zeros to every adjacency word, one word a cycle
// (MAX_VERTICES * MAX_VERTICES/64 words, 1024 at the default), with s_tready low.
// Add and remove do a read-modify-write of the word in each row (RD_A, CHK_A, RD_B,
// CHK_B); when the edge bit already holds the asked value, only the first word is read.
// A degree query reads its words one by one through the single memory read port
// feeding one popcount accumulator; at most four words are read.
// Mask loads, bad vertices, self-loops and unknown requests go straight to done. The next beat is taken
// once the sequencer is idle; a finished result waits while the previous one is held on m_.
`default_nettype none

module adjacency_bitmatrix_degree_engine
    import abde_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Configuration write.
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [BLK_W-1:0]  cfg_data,    // [2:0] blocks_in_use
    // Request stream.
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [95:0]       s_tdata,     // [7:0] vertex, [15:8] other_vertex,
                                                // [17:16] mask_index, [81:18] mask_word,
                                                // [90:82] upper_bound, [95:91] zero
    input  wire logic [REQ_W-1:0]  s_tuser,     // [2:0] req_type
    // Result stream.
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,     // [8:0] degree_count, [23:9] edge_count
    output logic                   m_tuser      // [0] bad_vertex
);

    localparam int ROW_WORDS = MAX_VERTICES / WORD_BITS;
    localparam int LIM       = (ROW_WORDS < MASK_WORDS) ? ROW_WORDS : MASK_WORDS;
    localparam int DEPTH     = MAX_VERTICES * ROW_WORDS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD_A  = 3'd2;
    localparam logic [2:0] ST_CHK_A = 3'd3;
    localparam logic [2:0] ST_RD_B  = 3'd4;
    localparam logic [2:0] ST_CHK_B = 3'd5;
    localparam logic [2:0] ST_DEG   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    function automatic logic [AW-1:0] addr_of(input logic [VTX_W-1:0] row,
                                              input logic [MIDX_W-1:0] wi);
        return AW'(32'(row) * ROW_WORDS + 32'(wi));
    endfunction

    // Input field views.
    logic [VTX_W-1:0]     in_v;
    logic [VTX_W-1:0]     in_w;
    logic [MIDX_W-1:0]    in_midx;
    logic [WORD_BITS-1:0] in_mword;
    logic [DEG_W-1:0]     in_ub;

    assign in_v     = s_tdata[7:0];
    assign in_w     = s_tdata[15:8];
    assign in_midx  = s_tdata[17:16];
    assign in_mword = s_tdata[81:18];
    assign in_ub    = s_tdata[90:82];

    // State.
    logic [2:0]           state_reg, state_next;
    logic [BLK_W-1:0]     cfg_reg;
    logic [AW-1:0]        clr_addr_reg;
    logic [WORD_BITS-1:0] mask_reg [MASK_WORDS];
    logic [EDGE_W-1:0]    edge_reg, edge_next;
    logic [REQ_W-1:0]     req_reg;
    logic [VTX_W-1:0]     v_reg;
    logic [VTX_W-1:0]     w_reg;
    logic [DEG_W-1:0]     ub_reg;
    logic                 bad_reg;
    logic [BLK_W-1:0]     idx_reg;
    logic                 rd_pend_reg;
    logic [MIDX_W-1:0]    rd_idx_reg;
    logic                 m_valid_reg;
    logic [DEG_W-1:0]     m_deg_reg;
    logic [EDGE_W-1:0]    m_edge_reg;
    logic                 m_bad_reg;

    // Effective number of row words in use.
    logic [BLK_W-1:0] nb;
    always_comb begin
        if (cfg_reg == '0) begin
            nb = BLK_W'(1);
        end else if (cfg_reg > BLK_W'(LIM)) begin
            nb = BLK_W'(LIM);
        end else begin
            nb = cfg_reg;
        end
    end

    // Bad vertex checks on the incoming beat.
    logic in_bad_v, in_bad_w;
    assign in_bad_v = {1'b0, in_v[7:6]} >= nb;
    assign in_bad_w = {1'b0, in_w[7:6]} >= nb;

    // Memory and accumulator hookup.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata, mem_rdata;
    acc_ctl_t             acc_ctl;
    logic [WORD_BITS-1:0] acc_keep;
    logic [DEG_W-1:0]     acc_sum;

    abde_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    abde_popacc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .word    (mem_rdata),
        .keep    (acc_keep),
        .sum     (acc_sum)
    );

    // Addresses of the edge words in both rows and of the current degree word.
    logic [AW-1:0]        addr_a, addr_b, addr_deg;
    logic [WORD_BITS-1:0] bit_a, bit_b;
    logic                 present, change;

    assign addr_a   = addr_of(v_reg, w_reg[7:6]);
    assign addr_b   = addr_of(w_reg, v_reg[7:6]);
    assign addr_deg = addr_of(v_reg, idx_reg[MIDX_W-1:0]);
    assign bit_a    = WORD_BITS'(1) << w_reg[5:0];
    assign bit_b    = WORD_BITS'(1) << v_reg[5:0];
    assign present  = mem_rdata[w_reg[5:0]];
    assign change   = (req_reg == REQ_ADD) ? !present : present;

    // Keep mask for the word in the accumulator: vertex mask and upper-neighbor head.
    logic [WORD_BITS-1:0] head;
    assign head = ~WORD_BITS'(0) << (7'(v_reg[5:0]) + 7'd1);

    always_comb begin
        acc_keep = ~WORD_BITS'(0);
        if (req_reg != REQ_DEG_UP) begin
            acc_keep = mask_reg[rd_idx_reg];
        end
        if (req_reg != REQ_DEG_CAP && rd_idx_reg == v_reg[7:6]) begin
            acc_keep = acc_keep & head;
        end
    end

    // Output side is free for a new result.
    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // Capped result for the capped masked degree.
    logic [DEG_W-1:0] deg_final;
    assign deg_final = (req_reg == REQ_DEG_CAP && acc_sum >= ub_reg) ? ub_reg : acc_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer next state, memory ports and edge count.
    always_comb begin
        state_next  = state_reg;
        mem_we      = 1'b0;
        mem_waddr   = addr_a;
        mem_wdata   = '0;
        mem_raddr   = addr_deg;
        acc_ctl.clr = 1'b0;
        acc_ctl.add = rd_pend_reg;
        edge_next   = edge_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    acc_ctl.clr = 1'b1;
                    unique case (s_tuser) inside
                        REQ_ADD, REQ_REMOVE: begin
                            if (in_bad_v || in_bad_w || in_v == in_w) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_RD_A;
                            end
                        end
                        REQ_DEG_CAP, REQ_DEG_MUP, REQ_DEG_UP: begin
                            state_next = in_bad_v ? ST_DONE : ST_DEG;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_A: begin
                mem_raddr  = addr_a;
                state_next = ST_CHK_A;
            end
            ST_CHK_A: begin
                if (change) begin
                    mem_we     = 1'b1;
                    mem_waddr  = addr_a;
                    mem_wdata  = (req_reg == REQ_ADD) ? (mem_rdata | bit_a)
                                                      : (mem_rdata & ~bit_a);
                    state_next = ST_RD_B;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_B: begin
                mem_raddr  = addr_b;
                state_next = ST_CHK_B;
            end
            ST_CHK_B: begin
                mem_we    = 1'b1;
                mem_waddr = addr_b;
                if (req_reg == REQ_ADD) begin
                    mem_wdata = mem_rdata | bit_b;
                    if (edge_reg != '1) begin
                        edge_next = edge_reg + EDGE_W'(1);
                    end
                end else begin
                    mem_wdata = mem_rdata & ~bit_b;
                    if (edge_reg != '0) begin
                        edge_next = edge_reg - EDGE_W'(1);
                    end
                end
                state_next = ST_DONE;
            end
            ST_DEG: begin
                mem_raddr = addr_deg;
                if (idx_reg + BLK_W'(1) == nb) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The last word may still be in the accumulator this cycle.
                if (!rd_pend_reg && out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cfg_reg      <= BLK_W'(4);
            clr_addr_reg <= '0;
            edge_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < MASK_WORDS; k++) begin
                mask_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            edge_reg    <= edge_next;
            rd_pend_reg <= (state_reg == ST_DEG);
            if (cfg_valid) begin
                cfg_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == ST_IDLE && s_tvalid && s_tuser == REQ_MASK) begin
                mask_reg[in_midx] <= in_mword;
            end
            if (state_reg == ST_DONE && !rd_pend_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            req_reg <= s_tuser;
            v_reg   <= in_v;
            w_reg   <= in_w;
            ub_reg  <= in_ub;
            idx_reg <= (s_tuser == REQ_DEG_CAP) ? '0 : {1'b0, in_v[7:6]};
            unique case (s_tuser) inside
                REQ_ADD, REQ_REMOVE: bad_reg <= in_bad_v || in_bad_w;
                REQ_DEG_CAP, REQ_DEG_MUP, REQ_DEG_UP: bad_reg <= in_bad_v;
                default: bad_reg <= 1'b0;
            endcase
        end else if (state_reg == ST_DEG) begin
            idx_reg <= idx_reg + BLK_W'(1);
        end
        if (state_reg == ST_DEG) begin
            rd_idx_reg <= idx_reg[MIDX_W-1:0];
        end
        if (state_reg == ST_DONE && !rd_pend_reg && out_free) begin
            m_deg_reg  <= deg_final;
            m_edge_reg <= edge_reg;
            m_bad_reg  <= bad_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_edge_reg, m_deg_reg};
    assign m_tuser  = m_bad_reg;

    // The edge count moves by at most one per cycle.
    a_edge_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (edge_reg == $past(edge_reg)
                         || edge_reg == $past(edge_reg) + EDGE_W'(1)
                         || edge_reg == $past(edge_reg) - EDGE_W'(1)))
        else $error("edge count jumped");

    // The memory is never written while the sequencer is idle.
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg != ST_IDLE)
        else $error("memory write while idle");

    // Degree reads stay within the row words in use.
    a_deg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DEG |-> idx_reg < nb)
        else $error("degree word index out of range");

    // A degree result is never above 256, the number of vertices in one row at the default size.
    a_deg_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_deg_reg <= DEG_W'(256))
        else $error("degree result out of range");

endmodule

`default_nettype wire
